// File: rtl/mob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mob_pkg
// Shared types, constants and the overlay palette for the mask overlay blend.
// ----------------------------------------------------------------------------
package mob_pkg;

  // frame dimensions above this are clamped
  localparam int MAX_FRAME_DIM = 4096;

  // config port shape
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // x * mask_width: 12 x 9 bits
  localparam int NUM_W = 21;
  // scaled coordinate, below mask_width so at most 9 bits
  localparam int Q_W   = 9;
  // my * mask_width + mx
  localparam int IDX_W = 18;

  localparam logic [8:0] ALPHA_MAX = 9'd256;

  typedef enum logic {
    CMD_MASK_WRITE = 1'b0,
    CMD_PIXEL      = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_MASK_WIDTH   = 3'd2,
    REG_MASK_HEIGHT  = 3'd3,
    REG_OBJECT_ID    = 3'd4,
    REG_BLEND_ALPHA  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // item travelling down the pipeline
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] mask_addr;
    logic        mask_set;
    rgb_t        pix;
    logic        in_frame;
  } item_t;

  // overlay colors, selected by object id mod 10
  function automatic rgb_t palette_color(input logic [3:0] sel);
    rgb_t c;
    unique case (sel)
      4'd0:    c = '{8'd239, 8'd71,  8'd111};
      4'd1:    c = '{8'd17,  8'd138, 8'd178};
      4'd2:    c = '{8'd255, 8'd209, 8'd102};
      4'd3:    c = '{8'd6,   8'd214, 8'd160};
      4'd4:    c = '{8'd155, 8'd93,  8'd229};
      4'd5:    c = '{8'd251, 8'd133, 8'd0};
      4'd6:    c = '{8'd42,  8'd157, 8'd143};
      4'd7:    c = '{8'd231, 8'd111, 8'd81};
      4'd8:    c = '{8'd38,  8'd70,  8'd83};
      4'd9:    c = '{8'd244, 8'd162, 8'd97};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/mob_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mob_in_if / mob_out_if
// Valid/ready channels for incoming mask writes and pixels, and blended pixels.
// ----------------------------------------------------------------------------
interface mob_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] mask_addr;
  logic        mask_set;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;

  modport source (
    output valid, command, mask_addr, mask_set, pixel_x, pixel_y,
           red_in, green_in, blue_in,
    input  ready
  );
  modport sink (
    input  valid, command, mask_addr, mask_set, pixel_x, pixel_y,
           red_in, green_in, blue_in,
    output ready
  );
endinterface

interface mob_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       covered;

  modport source (
    output valid, red_out, green_out, blue_out, covered,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, covered,
    output ready
  );
endinterface

// File: rtl/mob_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mob_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mob_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]      wdata,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read data holds while idle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/mob_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mob_div
// Pipelined restoring divider, one quotient bit per stage, for x and y at once.
// ----------------------------------------------------------------------------
module mob_div import mob_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  item_t            in_item,
  input  logic [NUM_W-1:0] num_x,
  input  logic [NUM_W-1:0] num_y,
  input  logic [12:0]      div_x,
  input  logic [12:0]      div_y,
  output logic             out_valid,
  output item_t            out_item,
  output logic [Q_W-1:0]   qx,
  output logic [Q_W-1:0]   qy
);

  localparam int RW = NUM_W + 1;

  logic             v  [Q_W];
  item_t            it [Q_W];
  logic [NUM_W-1:0] rx [Q_W];
  logic [NUM_W-1:0] ry [Q_W];
  logic [Q_W-1:0]   bx [Q_W];
  logic [Q_W-1:0]   by [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int K = Q_W - 1 - j;

    logic             pv;
    item_t            pit;
    logic [NUM_W-1:0] prx, pry;
    logic [Q_W-1:0]   pbx, pby;
    logic [RW-1:0]    dx, dy;
    logic             tx, ty;

    // previous stage or module input
    if (j == 0) begin : g_first
      assign pv  = in_valid;
      assign pit = in_item;
      assign prx = num_x;
      assign pry = num_y;
      assign pbx = '0;
      assign pby = '0;
    end else begin : g_next
      assign pv  = v[j-1];
      assign pit = it[j-1];
      assign prx = rx[j-1];
      assign pry = ry[j-1];
      assign pbx = bx[j-1];
      assign pby = by[j-1];
    end

    // trial subtract of the shifted divisor
    assign dx = RW'(div_x) << K;
    assign dy = RW'(div_y) << K;
    assign tx = ({1'b0, prx} >= dx);
    assign ty = ({1'b0, pry} >= dy);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it[j] <= pit;
        rx[j] <= tx ? NUM_W'({1'b0, prx} - dx) : prx;
        ry[j] <= ty ? NUM_W'({1'b0, pry} - dy) : pry;
        bx[j] <= pbx | (tx ? (Q_W'(1) << K) : '0);
        by[j] <= pby | (ty ? (Q_W'(1) << K) : '0);
      end
    end
  end

  assign out_valid = v[Q_W-1];
  assign out_item  = it[Q_W-1];
  assign qx        = bx[Q_W-1];
  assign qy        = by[Q_W-1];

  // a word moves one stage per enabled cycle
  a_step_moves: assert property (@(posedge clk) disable iff (rst)
    en && v[Q_W-2] |=> v[Q_W-1])
    else $error("divider stage lost a word");

endmodule

// File: rtl/mob_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mob_blend
// Alpha blend of pixel and overlay color, with the output register.
// ----------------------------------------------------------------------------
module mob_blend import mob_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  logic       hit,
  input  rgb_t       pix,
  input  rgb_t       color,
  input  logic [8:0] alpha,
  output logic       out_valid,
  output rgb_t       out_pix,
  output logic       out_covered
);

  // (p * (256 - a) + c * a) >> 8, alpha already clamped to 256
  function automatic logic [7:0] mix(input logic [7:0] p, input logic [7:0] c,
                                     input logic [8:0] a);
    logic [8:0]  inv;
    logic [16:0] sum;
    inv = 9'(10'd256 - 10'(a));
    sum = 17'(p) * 17'(inv) + 17'(c) * 17'(a);
    return sum[15:8];
  endfunction

  rgb_t mixed;

  always_comb begin
    mixed.r = mix(pix.r, color.r, alpha);
    mixed.g = mix(pix.g, color.g, alpha);
    mixed.b = mix(pix.b, color.b, alpha);
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_pix     <= hit ? mixed : pix;
      out_covered <= hit;
    end
  end

endmodule

// File: rtl/mask_overlay_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_overlay_blend_unit
// Overlays a colored segmentation mask on an RGB pixel stream. Mask writes
// fill a one-bit mask memory; pixels are scaled to the mask by nearest
// neighbor, look up their mask bit and get alpha blended with a palette color.
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    command, mask_addr, mask_set, x, y, rgb
//   out_ch   out  valid/ready    red_out, green_out, blue_out, covered
//   cfg      in   cfg_we         cfg_index, cfg_data
//
// One word accepted per cycle while the output is not stalled. Depth is set
// by the 9-stage coordinate divider and the one mask RAM port, which every
// word uses once at a single stage (in order). Mask writes give no result.
// Reset clears the pipeline valids and config; the mask RAM is not cleared.
// An output stall freezes the whole pipeline.
// ----------------------------------------------------------------------------
module mask_overlay_blend_unit import mob_pkg::*; #(
  parameter int MASK_ENTRIES = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  mob_in_if.sink                 in_ch,
  mob_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MASK_ENTRIES > 1) ? $clog2(MASK_ENTRIES) : 1;

  // config registers
  logic [12:0]        frame_width;
  logic [12:0]        frame_height;
  logic [8:0]         mask_width;
  logic [8:0]         mask_height;
  logic signed [15:0] object_id;
  logic [8:0]         blend_alpha;

  // palette index from object id
  logic [15:0] obj_u;
  logic [31:0] obj_prod;
  logic [15:0] obj_u_d;
  logic [12:0] obj_q;
  logic [15:0] obj_rem;
  logic [3:0]  rem0;
  logic [3:0]  color_idx;

  logic [12:0] fw_sat, fh_sat;
  logic [8:0]  alpha_sat;
  logic        en;

  // pipeline stages
  logic             s0_valid;
  item_t            s0_item;
  logic [11:0]      s0_x, s0_y;
  logic             s1_valid;
  item_t            s1_item;
  logic [NUM_W-1:0] s1_num_x, s1_num_y;
  logic             in_frame;
  logic             dv_valid;
  item_t            dv_item;
  logic [Q_W-1:0]   dv_qx, dv_qy;
  logic [IDX_W-1:0] idx_full;
  logic             s2_valid;
  item_t            s2_item;
  logic [IDX_W-1:0] s2_idx;
  logic             s2_ok;
  logic             s2_wr_ok;
  logic             s3_valid;
  item_t            s3_item;
  logic             s3_ok;

  // mask RAM port
  logic          ram_en, ram_we;
  logic [31:0]   ram_addr_full;
  logic [AW-1:0] ram_addr;
  logic [0:0]    ram_rdata;

  // blend output
  logic bl_valid;
  rgb_t bl_pix;
  logic bl_covered;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 13'd640;
      frame_height <= 13'd480;
      mask_width   <= 9'd256;
      mask_height  <= 9'd256;
      object_id    <= 16'sd0;
      blend_alpha  <= 9'd128;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[12:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        REG_MASK_WIDTH:   mask_width   <= cfg_data[8:0];
        REG_MASK_HEIGHT:  mask_height  <= cfg_data[8:0];
        REG_OBJECT_ID:    object_id    <= signed'(cfg_data);
        REG_BLEND_ALPHA:  blend_alpha  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // object id mod 10: offset by 32768 (= 8 mod 10), reciprocal multiply
  assign obj_u    = {~object_id[15], object_id[14:0]};
  assign obj_prod = 32'(obj_u) * 32'd52429;
  assign obj_rem  = obj_u_d - (16'(obj_q) << 3) - (16'(obj_q) << 1);
  assign rem0     = obj_rem[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      obj_u_d   <= 16'h8000;
      obj_q     <= 13'd3276;
      color_idx <= 4'd0;
    end else begin
      obj_u_d   <= obj_u;
      obj_q     <= obj_prod[31:19];
      color_idx <= (rem0 >= 4'd8) ? (rem0 - 4'd8) : (rem0 + 4'd2);
    end
  end

  // clamped settings
  assign fw_sat    = (32'(frame_width) > MAX_FRAME_DIM) ? 13'(MAX_FRAME_DIM) : frame_width;
  assign fh_sat    = (32'(frame_height) > MAX_FRAME_DIM) ? 13'(MAX_FRAME_DIM) : frame_height;
  assign alpha_sat = (blend_alpha > ALPHA_MAX) ? ALPHA_MAX : blend_alpha;

  // whole pipeline moves unless the output word is stalled
  assign en          = !bl_valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item <= '{cmd:       cmd_t'(in_ch.command),
                   mask_addr: in_ch.mask_addr,
                   mask_set:  in_ch.mask_set,
                   pix:       '{in_ch.red_in, in_ch.green_in, in_ch.blue_in},
                   in_frame:  1'b0};
      s0_x    <= in_ch.pixel_x;
      s0_y    <= in_ch.pixel_y;
    end
  end

  // stage 1: frame check and scale numerators
  assign in_frame = (fw_sat != '0) && (fh_sat != '0) && (mask_width != '0) &&
                    (mask_height != '0) && (13'(s0_x) < fw_sat) && (13'(s0_y) < fh_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item  <= '{cmd:       s0_item.cmd,
                    mask_addr: s0_item.mask_addr,
                    mask_set:  s0_item.mask_set,
                    pix:       s0_item.pix,
                    in_frame:  in_frame};
      s1_num_x <= NUM_W'(s0_x) * NUM_W'(mask_width);
      s1_num_y <= NUM_W'(s0_y) * NUM_W'(mask_height);
    end
  end

  // nearest neighbor scale: floor(num / frame dim)
  mob_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .in_item   (s1_item),
    .num_x     (s1_num_x),
    .num_y     (s1_num_y),
    .div_x     (fw_sat),
    .div_y     (fh_sat),
    .out_valid (dv_valid),
    .out_item  (dv_item),
    .qx        (dv_qx),
    .qy        (dv_qy)
  );

  // stage 2: mask index and range checks
  assign idx_full = IDX_W'(dv_qy) * IDX_W'(mask_width) + IDX_W'(dv_qx);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_item  <= dv_item;
      s2_idx   <= idx_full;
      s2_ok    <= dv_item.in_frame && (32'(idx_full) < MASK_ENTRIES);
      s2_wr_ok <= (32'(dv_item.mask_addr) < MASK_ENTRIES);
    end
  end

  // mask RAM access, writes and reads in arrival order
  assign ram_en        = en && s2_valid;
  assign ram_we        = (s2_item.cmd == CMD_MASK_WRITE) && s2_wr_ok;
  assign ram_addr_full = (s2_item.cmd == CMD_MASK_WRITE) ? 32'(s2_item.mask_addr)
                                                         : 32'(s2_idx);
  assign ram_addr      = ram_addr_full[AW-1:0];

  mob_ram #(
    .WIDTH (1),
    .DEPTH (MASK_ENTRIES)
  ) u_mask_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (s2_item.mask_set),
    .rdata (ram_rdata)
  );

  // stage 3: wait for read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_item <= s2_item;
      s3_ok   <= s2_ok;
    end
  end

  // blend and output register
  mob_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s3_valid && (s3_item.cmd == CMD_PIXEL)),
    .hit         (s3_ok && ram_rdata[0]),
    .pix         (s3_item.pix),
    .color       (palette_color(color_idx)),
    .alpha       (alpha_sat),
    .out_valid   (bl_valid),
    .out_pix     (bl_pix),
    .out_covered (bl_covered)
  );

  assign out_ch.valid     = bl_valid;
  assign out_ch.red_out   = bl_pix.r;
  assign out_ch.green_out = bl_pix.g;
  assign out_ch.blue_out  = bl_pix.b;
  assign out_ch.covered   = bl_covered;

  // mask writes never reach the output
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    en && s3_valid && (s3_item.cmd == CMD_MASK_WRITE) |=> !out_ch.valid)
    else $error("mask write produced an output word");

  // every pixel produces an output word
  a_pixel_out: assert property (@(posedge clk) disable iff (rst)
    en && s3_valid && (s3_item.cmd == CMD_PIXEL) |=> out_ch.valid)
    else $error("pixel lost before output");

  // stall freezes the stages around the RAM
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(s2_valid) && $stable(s3_valid))
    else $error("pipeline moved during stall");

  // palette index stays within the ten colors
  a_color_range: assert property (@(posedge clk) disable iff (rst)
    color_idx <= 4'd9)
    else $error("palette index out of range");

endmodule
